// File: rtl/mt19937_random_generator_defines.svh
// Assertion helpers for the MT19937 generator.
`ifndef MT19937_RANDOM_GENERATOR_DEFINES_SVH
`define MT19937_RANDOM_GENERATOR_DEFINES_SVH

// Implication checked on every edge outside reset.
`define MT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mt_pkg.sv
package mt_pkg;

    typedef enum logic [1:0] {
        KIND_RESEED = 2'd0,
        KIND_RAW    = 2'd1,
        KIND_RANGE  = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        seed_value;
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
    } t_mt_in;

    typedef struct packed {
        logic [31:0]        raw_word;
        logic signed [31:0] ranged_value;
    } t_mt_out;

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: rtl/mt_ram.sv
module mt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/mt19937_random_generator.sv
// MT19937 generator. Requests: reseed (no result), raw draw, ranged draw.
// The 624-word state sits in three copies of a one-write, one-read RAM so a
// twist reads words k, k+1 and k+397 in parallel. A reseed makes one word at
// a time via a registered 32x32 multiply (S_SEED_MUL, S_SEED_WR); a twist
// goes word by word (S_TW_RD, S_TW_WAIT, S_TW_WR) on the first draw after
// seeding, then on every 624th draw. A draw before any seeding adds a reseed
// first. A draw reads, tempers and registers a word (S_DRAW_RD, S_DRAW_WAIT,
// S_DRAW_TEMP, S_OUT); a ranged draw also passes the bit-serial 33-bit
// remainder unit (S_MOD) before S_OUT. Equal bounds give a result in the
// cycle after acceptance. A finished result sits in an output register; the
// next request is taken once it is taken. The block takes one at a time.
`include "mt19937_random_generator_defines.svh"

module mt19937_random_generator #(
    parameter int STATE_WORDS  = 624,
    parameter int SHIFT_OFFSET = 397
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mt_pkg::t_mt_in  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output mt_pkg::t_mt_out o_data
);
    import mt_pkg::*;

    localparam int AW = $clog2(STATE_WORDS + 2);
    localparam int RW = $clog2(STATE_WORDS);
    localparam logic [AW-1:0] N_USED   = AW'(STATE_WORDS);
    localparam logic [AW-1:0] N_UNSEED = AW'(STATE_WORDS + 1);
    localparam logic [RW-1:0] LAST     = RW'(STATE_WORDS - 1);
    localparam logic [RW-1:0] FAR0     = RW'(SHIFT_OFFSET);

    typedef enum logic [3:0] {
        S_IDLE, S_SEED_MUL, S_SEED_WR, S_TW_RD, S_TW_WAIT, S_TW_WR,
        S_DRAW_RD, S_DRAW_WAIT, S_DRAW_TEMP, S_MOD, S_OUT
    } t_state;

    t_state       r_state;
    logic [AW-1:0] r_index;
    logic [RW-1:0] r_k;
    logic [31:0]  r_prev;
    logic [31:0]  r_prod;
    logic [1:0]   r_kind;
    logic [32:0]  r_span;
    logic [32:0]  r_rem;
    logic [31:0]  r_word;
    logic [31:0]  r_lo;
    logic [5:0]   r_bit;
    t_mt_out      r_out;
    logic         r_out_valid;
    logic         r_draw_pend;

    // RAM ports
    logic          ram_we;
    logic [RW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [RW-1:0] ra_a, ra_b, ra_c;
    logic [31:0]   rd_a, rd_b, rd_c;

    mt_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram_a (
        .i_clk, .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ra_a), .o_rdata(rd_a));
    mt_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram_b (
        .i_clk, .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ra_b), .o_rdata(rd_b));
    mt_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram_c (
        .i_clk, .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ra_c), .o_rdata(rd_c));

    logic [RW-1:0] k_next, k_far;
    logic [31:0]   tw_y, tw_val, mixed;
    logic [33:0]   rem_sh;
    logic          accept;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        k_next = (r_k == LAST) ? '0 : r_k + 1'b1;
        if ({1'b0, r_k} >= (RW + 1)'(STATE_WORDS - SHIFT_OFFSET)) begin
            k_far = RW'({1'b0, r_k} - (RW + 1)'(STATE_WORDS - SHIFT_OFFSET));
        end else begin
            k_far = r_k + FAR0;
        end
        tw_y   = {rd_a[31], rd_b[30:0]};
        tw_val = rd_c ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MATRIX : 32'd0);
        mixed  = r_prev ^ (r_prev >> 30);
        rem_sh = {r_rem, r_word[31]};
        ra_a = r_k;
        ra_b = k_next;
        ra_c = k_far;
        if (r_state == S_DRAW_RD || r_state == S_DRAW_WAIT) begin
            ra_a = r_index[RW-1:0];
        end
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = tw_val;
        if (r_state == S_SEED_WR) begin
            ram_we    = 1'b1;
            ram_wdata = r_prod + 32'(r_k);
        end else if (r_state == S_TW_WR) begin
            ram_we = 1'b1;
        end else if (r_state == S_SEED_MUL && r_k == RW'(1)) begin
            // seed word goes to word 0 while word 1 is being computed
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_index     <= N_UNSEED;
            r_out_valid <= 1'b0;
            r_draw_pend <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= i_data.kind;
                        case (t_kind'(i_data.kind))
                            KIND_RESEED: begin
                                r_prev      <= i_data.seed_value;
                                r_k         <= RW'(1);
                                r_draw_pend <= 1'b0;
                                r_state     <= S_SEED_MUL;
                            end
                            KIND_RAW, KIND_RANGE: begin
                                if (i_data.kind == KIND_RANGE &&
                                    i_data.range_min == i_data.range_max) begin
                                    r_out.raw_word     <= '0;
                                    r_out.ranged_value <= i_data.range_min;
                                    r_out_valid        <= 1'b1;
                                end else begin
                                    if (i_data.range_min < i_data.range_max) begin
                                        r_lo   <= i_data.range_min;
                                        r_span <= 33'({i_data.range_max[31], i_data.range_max}
                                            - {i_data.range_min[31], i_data.range_min}) + 33'd1;
                                    end else begin
                                        r_lo   <= i_data.range_max;
                                        r_span <= 33'({i_data.range_min[31], i_data.range_min}
                                            - {i_data.range_max[31], i_data.range_max}) + 33'd1;
                                    end
                                    if (r_index == N_UNSEED) begin
                                        r_prev      <= DEFAULT_SEED;
                                        r_k         <= RW'(1);
                                        r_draw_pend <= 1'b1;
                                        r_state     <= S_SEED_MUL;
                                    end else if (r_index == N_USED) begin
                                        r_k     <= '0;
                                        r_state <= S_TW_RD;
                                    end else begin
                                        r_state <= S_DRAW_RD;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SEED_MUL: begin
                    r_prod  <= 32'(mixed * SEED_MULT);
                    r_state <= S_SEED_WR;
                end
                S_SEED_WR: begin
                    r_prev <= r_prod + 32'(r_k);
                    if (r_k == LAST) begin
                        r_index <= N_USED;
                        r_k     <= '0;
                        r_state <= r_draw_pend ? S_TW_RD : S_IDLE;
                        r_draw_pend <= 1'b0;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SEED_MUL;
                    end
                end
                S_TW_RD:   r_state <= S_TW_WAIT;
                S_TW_WAIT: r_state <= S_TW_WR;
                S_TW_WR: begin
                    if (r_k == LAST) begin
                        r_index <= '0;
                        r_state <= S_DRAW_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_TW_RD;
                    end
                end
                S_DRAW_RD:   r_state <= S_DRAW_WAIT;
                S_DRAW_WAIT: r_state <= S_DRAW_TEMP;
                S_DRAW_TEMP: begin
                    r_word  <= temper(rd_a);
                    r_index <= r_index + 1'b1;
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_state <= S_MOD;
                    if (r_kind == KIND_RAW) begin
                        r_state <= S_OUT;
                    end
                end
                S_MOD: begin
                    // restoring remainder, one dividend bit per cycle
                    if (rem_sh >= {1'b0, r_span}) begin
                        r_rem <= 33'(rem_sh - {1'b0, r_span});
                    end else begin
                        r_rem <= rem_sh[32:0];
                    end
                    r_word <= {r_word[30:0], r_word[31]};
                    r_bit  <= r_bit + 1'b1;
                    if (r_bit == 6'd31) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_out.raw_word     <= r_word;
                    r_out.ranged_value <= (r_kind == KIND_RAW) ? 32'sd0
                                          : $signed(r_lo + r_rem[31:0]);
                    r_out_valid        <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MT_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !o_ready, "ready while busy")
    `MT_ASSERT_IMP(a_index_range, i_clk, i_rst_n, 1'b1, r_index <= N_UNSEED, "word index out of range")
    `MT_ASSERT_NEXT(a_out_after_accept, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "result dropped")
endmodule
